/* rtl/rept_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rept_pkg: shared types and constants of the encoder position/speed tracker
// Field widths, register indexes, fixed-point constants of the speed path and
// the request/response structs between the top level and the speed unit.
// ----------------------------------------------------------------------------
package rept_pkg;

    // Geometry
    localparam int ANGLE_BITS_DEF = 12;
    localparam int ANGLE_W        = 12;
    localparam int TIME_W         = 32;
    localparam int POS_W          = 32;
    localparam int SPEED_W        = 24;

    // Stream payload widths (whole bytes)
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 72;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED_DT    = 2'd1;
    localparam logic [CFG_W-1:0]     SAMPLE_INTERVAL_RST = 8'd10;
    localparam logic [CFG_W-1:0]     MIN_SPEED_DT_RST    = 8'd8;

    // Angle delta, wide enough for the largest angle resolution
    localparam int DELTA_W = 18;
    localparam int MAG_W   = 17;

    // Instant speed: |d| * 360 * 1000 * 256, then divided by dt * 2^ANGLE_BITS
    localparam int DIV_W     = 32;
    localparam int PROD_W    = 44;
    localparam int NUM_SUM_W = 48;
    localparam int K_W       = 27;
    localparam logic [K_W-1:0] SPEED_K = 27'd92160000;

    // Filter: weighted sum over ten, rounded via reciprocal of ten
    localparam int SUM_W       = 29;
    localparam int FILT_MAG_W  = 28;
    localparam int FILT_PROD_W = 60;
    localparam int RECIP_SHIFT = 35;
    localparam int FILT_Q_W    = FILT_PROD_W - RECIP_SHIFT;
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam logic [FILT_MAG_W-1:0] ROUND_TEN = 28'd5;

    // Alpha weights in tenths
    localparam int ALPHA_W = 4;
    localparam logic [ALPHA_W-1:0] ALPHA_SLOW = 4'd3;
    localparam logic [ALPHA_W-1:0] ALPHA_MID  = 4'd4;
    localparam logic [ALPHA_W-1:0] ALPHA_FAST = 4'd6;
    localparam logic [ALPHA_W-1:0] ALPHA_ALL  = 4'd10;

    // Q8 speed limits and thresholds (magnitudes)
    localparam logic [SPEED_W-1:0] SPEED_POS_MAX = 24'd8388607;
    localparam logic [SPEED_W-1:0] SPEED_NEG_MAX = 24'd8388608;
    localparam logic [SPEED_W-1:0] SLOW_LIM_Q8   = 24'd7680;
    localparam logic [SPEED_W-1:0] FAST_LIM_Q8   = 24'd17920;
    localparam logic [SPEED_W-1:0] UNIT_Q8       = 24'd256;

    // Speed unit request and response
    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic [TIME_W-1:0]         dt;
        logic signed [SPEED_W-1:0] speed;
    } spd_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [SPEED_W-1:0] speed;
    } spd_rsp_t;

endpackage

/* rtl/rept_serdiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rept_serdiv: bit-serial restoring divider
// One quotient bit per cycle: the dividend shifts out of the quotient register
// into the partial remainder while quotient bits shift in behind it.
// ----------------------------------------------------------------------------
module rept_serdiv (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rept_pkg::DIV_W-1:0] num,
    input  logic [rept_pkg::DIV_W-1:0] den,
    output logic                       done,
    output logic [rept_pkg::DIV_W-1:0] quo
);

    localparam int DW    = rept_pkg::DIV_W;
    localparam int CNT_W = $clog2(DW);

    logic            busy_reg;
    logic            done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW:0]     rem_reg;
    logic [DW-1:0]   quo_reg;
    logic [DW-1:0]   den_reg;

    logic [DW:0]     rem_sh;
    logic            fits;
    logic [DW:0]     rem_next;
    logic [DW-1:0]   quo_next;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        rem_sh   = {rem_reg[DW-1:0], quo_reg[DW-1]};
        fits     = (rem_sh >= {1'b0, den_reg});
        rem_next = fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        quo_next = {quo_reg[DW-2:0], fits};
    end

    // Step counter and shift registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            // Flag the cycle after the last quotient bit
            done_reg <= busy_reg && !start && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DW - 1);
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/rept_speed.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rept_speed: instant speed and adaptive exponential filter
// Scales the angle delta, divides by the elapsed time on the serial divider,
// saturates, picks the filter weight and blends with the previous speed.
// ----------------------------------------------------------------------------
module rept_speed #(
    parameter int ANGLE_BITS = rept_pkg::ANGLE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  rept_pkg::spd_req_t req,
    output rept_pkg::spd_rsp_t rsp
);

    localparam int MW  = rept_pkg::MAG_W;
    localparam int PW  = rept_pkg::PROD_W;
    localparam int NW  = rept_pkg::NUM_SUM_W;
    localparam int DVW = rept_pkg::DIV_W;
    localparam int SPW = rept_pkg::SPEED_W;
    localparam int SW  = rept_pkg::SUM_W;
    localparam int FMW = rept_pkg::FILT_MAG_W;
    localparam int FPW = rept_pkg::FILT_PROD_W;
    localparam int FQW = rept_pkg::FILT_Q_W;
    localparam int AW  = rept_pkg::ALPHA_W;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_NUM, S_DIV, S_SUM, S_REC, S_OUT
    } spd_state_t;

    spd_state_t             state_reg;
    logic                   neg_reg;
    logic [MW-1:0]          mag_reg;
    logic [DVW-1:0]         dt_reg;
    logic signed [SPW-1:0]  old_reg;
    logic [PW-1:0]          prod_reg;
    logic signed [SPW-1:0]  inst_reg;
    logic [AW-1:0]          alpha_reg;
    logic signed [SW-1:0]   sum_reg;
    logic                   fneg_reg;
    logic [FPW-1:0]         fprod_reg;
    rept_pkg::spd_rsp_t     rsp_reg;

    logic [PW-1:0]          prod_next;
    logic [NW-1:0]          num_sum;
    logic [DVW-1:0]         div_num;
    logic                   div_start;
    logic                   div_done;
    logic [DVW-1:0]         div_quo;
    logic [SPW-1:0]         q_lim;
    logic [SPW-1:0]         q_mag;
    logic signed [SPW-1:0]  inst_next;
    logic [AW-1:0]          alpha_next;
    logic signed [SW-1:0]   inst_ext;
    logic signed [SW-1:0]   old_ext;
    logic signed [SW-1:0]   a_ext;
    logic signed [SW-1:0]   b_ext;
    logic signed [SW-1:0]   sum_next;
    logic [SW-1:0]          sum_abs;
    logic [FMW-1:0]         fnum;
    logic [FPW-1:0]         fprod_next;
    logic [FQW-1:0]         fq;
    logic [SPW-1:0]         f_lim;
    logic [SPW-1:0]         f_mag;
    logic [SPW-1:0]         f_half;
    logic signed [SPW-1:0]  speed_next;

    // Scaled numerator, rounded by half the divisor and pre-shifted by 2^ANGLE_BITS
    always_comb begin
        prod_next = PW'(mag_reg) * PW'(rept_pkg::SPEED_K);
        num_sum   = NW'(prod_reg) + (NW'(dt_reg) << (ANGLE_BITS - 1));
        div_num   = DVW'(num_sum >> ANGLE_BITS);
        div_start = (state_reg == S_MUL) ? 1'b0 : (state_reg == S_NUM);
    end

    rept_serdiv u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (dt_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Saturate the instant speed and pick the filter weight
    always_comb begin
        q_lim     = neg_reg ? rept_pkg::SPEED_NEG_MAX : rept_pkg::SPEED_POS_MAX;
        q_mag     = (div_quo > DVW'(q_lim)) ? q_lim : div_quo[SPW-1:0];
        inst_next = neg_reg ? -$signed(q_mag) : $signed(q_mag);
        if (q_mag < rept_pkg::SLOW_LIM_Q8) begin
            alpha_next = rept_pkg::ALPHA_SLOW;
        end else if (q_mag < rept_pkg::FAST_LIM_Q8) begin
            alpha_next = rept_pkg::ALPHA_MID;
        end else begin
            alpha_next = rept_pkg::ALPHA_FAST;
        end
    end

    // Weighted blend in tenths, then round over ten by reciprocal
    always_comb begin
        inst_ext   = SW'(inst_reg);
        old_ext    = SW'(old_reg);
        a_ext      = $signed(SW'(alpha_reg));
        b_ext      = $signed(SW'(rept_pkg::ALPHA_ALL - alpha_reg));
        sum_next   = (a_ext * inst_ext) + (b_ext * old_ext);
        sum_abs    = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
        fnum       = FMW'(sum_abs) + rept_pkg::ROUND_TEN;
        fprod_next = FPW'(fnum) * FPW'(rept_pkg::RECIP_TEN);
    end

    // Saturate, halve below one degree per second, restore the sign
    always_comb begin
        fq         = fprod_reg[FPW-1:rept_pkg::RECIP_SHIFT];
        f_lim      = fneg_reg ? rept_pkg::SPEED_NEG_MAX : rept_pkg::SPEED_POS_MAX;
        f_mag      = (fq > FQW'(f_lim)) ? f_lim : fq[SPW-1:0];
        f_half     = (f_mag < rept_pkg::UNIT_Q8) ? (f_mag >> 1) : f_mag;
        speed_next = fneg_reg ? -$signed(f_half) : $signed(f_half);
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rsp_reg.done <= 1'b0;
        end else begin
            // Pulse done alongside the final speed
            rsp_reg.done <= (state_reg == S_OUT);
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        neg_reg   <= req.delta[rept_pkg::DELTA_W-1];
                        mag_reg   <= req.delta[rept_pkg::DELTA_W-1] ?
                                     MW'(-req.delta) : MW'(req.delta);
                        dt_reg    <= req.dt;
                        old_reg   <= req.speed;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= prod_next;
                    state_reg <= S_NUM;
                end
                S_NUM: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        inst_reg  <= inst_next;
                        alpha_reg <= alpha_next;
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    sum_reg   <= sum_next;
                    state_reg <= S_REC;
                end
                S_REC: begin
                    fneg_reg  <= sum_reg[SW-1];
                    fprod_reg <= fprod_next;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    rsp_reg.speed <= speed_next;
                    state_reg     <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp = rsp_reg;

endmodule

/* rtl/rotary_encoder_position_speed_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_position_speed_tracker: absolute encoder unwrap and speed
// Takes timestamped angle samples, unwraps them into a 32-bit position and
// keeps an adaptively filtered speed in signed Q15.8 degrees per second.
// ----------------------------------------------------------------------------
// Each input beat yields exactly one output beat. Set-position commands,
// samples dropped by the sample interval, the first sample after reset and
// samples too close to the last speed update go from accept straight to the
// emit state, which loads their result once the output register is free. A
// sample that recomputes the speed first waits on the speed unit: the
// elapsed-time division runs on a bit-serial divider at one quotient bit per
// cycle, around which sit the start hand-over, the scaling multiply, the
// divider launch, the done hand-back, the filter sum, reciprocal and output
// steps and the return to the tracker. One item is in work at a time; a
// finished result waits in the output register while the next beat is
// accepted, and a result held up by the sink stalls the input until the
// register frees. Configuration writes are taken at any time but belong
// between items.
// ----------------------------------------------------------------------------
module rotary_encoder_position_speed_tracker #(
    parameter int ANGLE_BITS = rept_pkg::ANGLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input beat
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: raw_angle[11:0], time_ms[43:12], new_position[75:44], zero pad
    input  logic [rept_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: cmd (0 sample, 1 set position)
    input  logic                           s_tuser,
    // Result beat
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: cumulative_position[31:0], angular_speed[55:32],
    //          current_angle[67:56], zero pad
    output logic [rept_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: accepted
    output logic                           m_tuser,
    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rept_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rept_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW  = rept_pkg::ANGLE_W;
    localparam int TW  = rept_pkg::TIME_W;
    localparam int PSW = rept_pkg::POS_W;
    localparam int SPW = rept_pkg::SPEED_W;
    localparam int DW  = rept_pkg::DELTA_W;
    localparam int CW  = rept_pkg::CFG_W;
    localparam int OPAD = rept_pkg::M_TDATA_W - PSW - SPW - AW;

    localparam logic [AW-1:0] ANGLE_MASK =
        (ANGLE_BITS >= AW) ? {AW{1'b1}} : AW'((1 << ANGLE_BITS) - 1);
    localparam logic signed [DW-1:0] HALF_TURN = DW'(1 << (ANGLE_BITS - 1));
    localparam logic signed [DW-1:0] FULL_TURN = DW'(1 << ANGLE_BITS);

    typedef enum logic [1:0] {
        ST_IDLE, ST_BUSY, ST_EMIT
    } trk_state_t;

    trk_state_t            state_reg;
    logic [CW-1:0]         interval_reg;
    logic [CW-1:0]         min_dt_reg;
    logic [TW-1:0]         last_time_reg;
    logic [AW-1:0]         cur_angle_reg;
    logic [PSW-1:0]        pos_reg;
    logic signed [SPW-1:0] speed_reg;
    logic [TW-1:0]         speed_time_reg;
    logic                  primed_reg;
    logic                  acc_reg;
    logic                  spd_start_reg;
    rept_pkg::spd_req_t    spd_req_reg;
    logic                  m_tvalid_reg;
    logic                  m_tuser_reg;
    logic [rept_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [AW-1:0]         angle_in;
    logic [TW-1:0]         time_in;
    logic [PSW-1:0]        newpos_in;
    logic [TW-1:0]         elapsed;
    logic                  take;
    logic signed [DW-1:0]  diff;
    logic signed [DW-1:0]  delta;
    logic [TW-1:0]         spd_dt;
    logic [CW-1:0]         min_dt_eff;
    logic                  dt_ok;
    rept_pkg::spd_rsp_t    spd_rsp;

    // Unpack the beat and judge the sample
    always_comb begin
        angle_in   = s_tdata[AW-1:0] & ANGLE_MASK;
        time_in    = s_tdata[AW+TW-1:AW];
        newpos_in  = s_tdata[AW+TW+PSW-1:AW+TW];
        elapsed    = time_in - last_time_reg;
        take       = (elapsed >= TW'(interval_reg));
        diff       = $signed(DW'(angle_in)) - $signed(DW'(cur_angle_reg));
        if (diff > HALF_TURN) begin
            delta = diff - FULL_TURN;
        end else if (diff < -HALF_TURN) begin
            delta = diff + FULL_TURN;
        end else begin
            delta = diff;
        end
        spd_dt     = time_in - speed_time_reg;
        min_dt_eff = (min_dt_reg == '0) ? CW'(1) : min_dt_reg;
        dt_ok      = (spd_dt >= TW'(min_dt_eff));
    end

    rept_speed #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_speed (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (spd_start_reg),
        .req     (spd_req_reg),
        .rsp     (spd_rsp)
    );

    // Tracker state, configuration and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            interval_reg   <= rept_pkg::SAMPLE_INTERVAL_RST;
            min_dt_reg     <= rept_pkg::MIN_SPEED_DT_RST;
            last_time_reg  <= '0;
            cur_angle_reg  <= '0;
            pos_reg        <= '0;
            speed_reg      <= '0;
            speed_time_reg <= '0;
            primed_reg     <= 1'b0;
            spd_start_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // Kick the speed unit for a primed sample due a speed update
            spd_start_reg <= (state_reg == ST_IDLE) && s_tvalid && !s_tuser &&
                             take && primed_reg && dt_ok;

            // Release the result once the beat is taken and nothing replaces it
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end

            // Register writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    rept_pkg::CFG_SAMPLE_INTERVAL: interval_reg <= cfg_data;
                    rept_pkg::CFG_MIN_SPEED_DT:    min_dt_reg   <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser) begin
                            pos_reg   <= newpos_in;
                            acc_reg   <= 1'b1;
                            state_reg <= ST_EMIT;
                        end else if (take) begin
                            acc_reg       <= 1'b1;
                            last_time_reg <= time_in;
                            cur_angle_reg <= angle_in;
                            pos_reg       <= pos_reg + PSW'(delta);
                            if (!primed_reg) begin
                                primed_reg     <= 1'b1;
                                speed_time_reg <= time_in;
                                speed_reg      <= '0;
                                state_reg      <= ST_EMIT;
                            end else if (dt_ok) begin
                                speed_time_reg    <= time_in;
                                spd_req_reg.delta <= delta;
                                spd_req_reg.dt    <= spd_dt;
                                spd_req_reg.speed <= speed_reg;
                                state_reg         <= ST_BUSY;
                            end else begin
                                state_reg <= ST_EMIT;
                            end
                        end else begin
                            acc_reg   <= 1'b0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_BUSY: begin
                    if (spd_rsp.done) begin
                        speed_reg <= spd_rsp.speed;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // Load the result once the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= acc_reg;
                        m_tdata_reg  <= {{OPAD{1'b0}}, cur_angle_reg, speed_reg, pos_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // A speed update only follows a primed timer
    a_start_primed : assert property (@(posedge aclk) disable iff (!aresetn)
        spd_start_reg |-> primed_reg)
        else $error("speed unit started before the timer was primed");

    // The speed unit only answers while the tracker waits for it
    a_done_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        spd_rsp.done |-> (state_reg == ST_BUSY))
        else $error("speed result arrived outside the busy state");

    // One item in work at a time
    a_one_item : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input beat accepted while an item was in work");

endmodule

/* verif/rotary_encoder_position_speed_tracker_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_position_speed_tracker_test: self-checking stream testbench
// Sends angle samples and set-position commands, tracks the expected unwrap,
// sample-interval drop and adaptive speed filter in a behavioural predictor,
// and compares each result beat field by field. Input gaps, output stalls, a
// long output hold-off and several register settings are exercised.
// ----------------------------------------------------------------------------
module rotary_encoder_position_speed_tracker_test;

    localparam int     ANGLE_W       = rept_pkg::ANGLE_W;
    localparam int     TIME_W        = rept_pkg::TIME_W;
    localparam int     POS_W         = rept_pkg::POS_W;
    localparam int     SPEED_W       = rept_pkg::SPEED_W;
    localparam int     CFG_W         = rept_pkg::CFG_W;
    localparam int     CFG_IDX_W     = rept_pkg::CFG_IDX_W;
    localparam int     S_TDATA_W     = rept_pkg::S_TDATA_W;
    localparam int     M_TDATA_W     = rept_pkg::M_TDATA_W;
    localparam int     CLK_HALF      = 10;
    localparam int     RESET_CYCLES  = 7;
    localparam int     SETTLE_CYCLES = 60;
    localparam int     LONG_HOLD     = 400;
    localparam int     SPEED_LSB     = POS_W;
    localparam int     ANGLE_LSB     = POS_W + SPEED_W;
    localparam int     S_PAD_W       = S_TDATA_W - ANGLE_W - TIME_W - POS_W;
    localparam longint FULL_TURN     = longint'(1) << ANGLE_W;
    localparam longint HALF_TURN     = longint'(1) << (ANGLE_W - 1);
    localparam longint DEG_SCALE     = 92160000;
    localparam longint Q8_TOP        = 8388607;
    localparam longint Q8_BOTTOM     = -8388608;
    localparam longint SLOW_BAND     = 7680;
    localparam longint FAST_BAND     = 17920;
    localparam longint ONE_DEG_Q8    = 256;

    typedef enum logic { CMD_SAMPLE = 1'b0, CMD_SET_POS = 1'b1 } tracker_cmd_t;
    typedef enum int { RX_STEADY, RX_RANDOM, RX_PATTERN, RX_BURSTY } sink_mode_t;

    typedef struct packed {
        logic                      accepted;
        logic [POS_W-1:0]          position;
        logic signed [SPEED_W-1:0] speed;
        logic [ANGLE_W-1:0]        angle;
    } tracker_report_t;

    // DUT connections
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Predicted block state and registers
    logic [TIME_W-1:0]         trk_last_time  = '0;
    logic [ANGLE_W-1:0]        trk_angle      = '0;
    logic [ANGLE_W-1:0]        trk_prev_angle = '0;
    logic [POS_W-1:0]          trk_position   = '0;
    logic signed [SPEED_W-1:0] trk_speed      = '0;
    logic [TIME_W-1:0]         trk_speed_time = '0;
    logic                      trk_primed     = 1'b0;
    logic [CFG_W-1:0]          trk_interval   = rept_pkg::SAMPLE_INTERVAL_RST;
    logic [CFG_W-1:0]          trk_min_dt     = rept_pkg::MIN_SPEED_DT_RST;

    tracker_report_t   pending_reports[$];
    int unsigned       error_count  = 0;
    int unsigned       burst_left   = 0;
    bit                tx_gaps      = 1'b0;
    bit                hold_request = 1'b0;
    sink_mode_t        rx_mode      = RX_STEADY;
    logic [TIME_W-1:0] stim_time    = '0;
    logic [ANGLE_W-1:0] stim_angle  = '0;

    rotary_encoder_position_speed_tracker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Divide rounding to nearest, ties away from zero; den is positive
    function automatic longint div_nearest(longint num, longint den);
        longint mag;
        longint quo;
        mag = (num < 0) ? -num : num;
        quo = (mag + den / 2) / den;
        return (num < 0) ? -quo : quo;
    endfunction

    function automatic longint clamp_q8(longint v);
        if (v > Q8_TOP) return Q8_TOP;
        if (v < Q8_BOTTOM) return Q8_BOTTOM;
        return v;
    endfunction

    // Apply one input beat to the predicted state and return its report
    function automatic tracker_report_t track_sample(tracker_cmd_t cmd,
                                                     logic [ANGLE_W-1:0] ang,
                                                     logic [TIME_W-1:0] tms,
                                                     logic [POS_W-1:0] npos);
        tracker_report_t   rep;
        logic [TIME_W-1:0] since_last;
        logic [TIME_W-1:0] since_speed;
        logic [TIME_W-1:0] floor_dt;
        longint            step;
        longint            ang_new;
        longint            ang_old;
        longint            elapsed;
        longint            inst;
        longint            mag;
        longint            alpha;
        longint            old_speed;
        longint            filt;
        rep.accepted = 1'b0;
        since_last = tms - trk_last_time;
        if (cmd == CMD_SET_POS) begin
            trk_position = npos;
            rep.accepted = 1'b1;
        end else if (since_last >= {{(TIME_W-CFG_W){1'b0}}, trk_interval}) begin
            // Unwrap the angle step into plus or minus half a turn
            ang_new = ang;
            ang_old = trk_angle;
            step = ang_new - ang_old;
            if (step > HALF_TURN) step = step - FULL_TURN;
            else if (step < -HALF_TURN) step = step + FULL_TURN;
            rep.accepted = 1'b1;
            trk_last_time = tms;
            trk_prev_angle = trk_angle;
            trk_angle = ang;
            trk_position = trk_position + step[POS_W-1:0];
            if (!trk_primed) begin
                // First sample only starts the speed timer
                trk_primed = 1'b1;
                trk_speed_time = tms;
                trk_speed = '0;
            end else begin
                since_speed = tms - trk_speed_time;
                floor_dt = (trk_min_dt == '0) ? 32'd1 : {{(TIME_W-CFG_W){1'b0}}, trk_min_dt};
                if (since_speed >= floor_dt) begin
                    elapsed = since_speed;
                    inst = clamp_q8(div_nearest(step * DEG_SCALE, elapsed << ANGLE_W));
                    mag = (inst < 0) ? -inst : inst;
                    if (mag < SLOW_BAND) alpha = 3;
                    else if (mag < FAST_BAND) alpha = 4;
                    else alpha = 6;
                    old_speed = trk_speed;
                    filt = clamp_q8(div_nearest(alpha * inst + (10 - alpha) * old_speed, 10));
                    if (filt > -ONE_DEG_Q8 && filt < ONE_DEG_Q8) filt = filt / 2;
                    trk_speed = filt[SPEED_W-1:0];
                    trk_speed_time = tms;
                end
            end
        end
        rep.position = trk_position;
        rep.speed = trk_speed;
        rep.angle = trk_angle;
        return rep;
    endfunction

    // Offer one beat, idling between bursts, and record its expected report
    task automatic send_beat(tracker_cmd_t cmd, logic [ANGLE_W-1:0] ang,
                             logic [TIME_W-1:0] tms, logic [POS_W-1:0] npos);
        if (tx_gaps && burst_left == 0) begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(9, 60)) @(posedge aclk);
            else repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{S_PAD_W{1'b0}}, npos, tms, ang};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0) burst_left--;
        pending_reports.push_back(track_sample(cmd, ang, tms, npos));
    endtask

    task automatic send_sample(logic [ANGLE_W-1:0] ang, logic [TIME_W-1:0] tms);
        logic [POS_W-1:0] junk;
        junk = $urandom;
        send_beat(CMD_SAMPLE, ang, tms, junk);
    endtask

    task automatic send_set_position(logic [POS_W-1:0] npos);
        logic [ANGLE_W-1:0] junk_ang;
        logic [TIME_W-1:0]  junk_time;
        junk_ang  = $urandom;
        junk_time = $urandom;
        send_beat(CMD_SET_POS, junk_ang, junk_time, npos);
    endtask

    // Drop valid and let every outstanding result come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write both registers back to back; valid stays high between the beats
    task automatic set_config(logic [CFG_W-1:0] ival, logic [CFG_W-1:0] mdt);
        cfg_valid <= 1'b1;
        cfg_index <= rept_pkg::CFG_SAMPLE_INTERVAL;
        cfg_data  <= ival;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        trk_interval = ival;
        cfg_index <= rept_pkg::CFG_MIN_SPEED_DT;
        cfg_data  <= mdt;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        trk_min_dt = mdt;
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed sample streams, with set commands and noise mixed in
    task automatic send_random_items(int unsigned count);
        int unsigned        pick;
        int unsigned        step_t;
        int                 step_ang;
        logic [TIME_W-1:0]  tms;
        logic [ANGLE_W-1:0] ang;
        logic [POS_W-1:0]   npos;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                npos = $urandom;
                send_set_position(npos);
            end else if (pick < 12) begin
                tms = $urandom;
                ang = $urandom;
                send_sample(ang, tms);
                stim_time = tms;
                stim_angle = ang;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 15 && trk_interval != 0) step_t = $urandom_range(0, trk_interval - 1);
                else if (pick < 25) step_t = trk_interval + $urandom_range(0, 5000);
                else step_t = trk_interval + $urandom_range(0, 2 * trk_min_dt + 16);
                pick = $urandom_range(0, 99);
                if (pick < 10) step_ang = 0;
                else if (pick < 55) step_ang = int'($urandom_range(0, 16)) - 8;
                else if (pick < 85) step_ang = int'($urandom_range(0, 600)) - 300;
                else step_ang = int'($urandom_range(0, 4096)) - 2048;
                tms = stim_time + step_t;
                ang = stim_angle + step_ang[ANGLE_W-1:0];
                send_sample(ang, tms);
                if (step_t >= trk_interval) begin
                    stim_time = tms;
                    stim_angle = ang;
                end
            end
        end
    endtask

    // Reset defaults: early drop, priming, half-turn unwrap, position wrap
    task automatic test_defaults_and_unwrap();
        rx_mode = RX_STEADY;
        tx_gaps = 1'b0;
        send_sample(12'd100, 32'd5);
        send_set_position(32'h7FFF_FFFF);
        send_sample(12'd0, 32'd10);
        send_sample(12'hFFF, 32'd15);
        send_sample(12'd2048, 32'd20);
        send_sample(12'd0, 32'd30);
        send_sample(12'd2049, 32'd40);
        send_sample(12'd0, 32'd50);
        send_sample(12'hFFF, 32'd59);
        send_sample(12'hFFF, 32'd60);
        send_set_position(32'h8000_0000);
        send_sample(12'd4090, 32'd70);
        drain_results();
    endtask

    // Saturation, zero intervals, skipped speed updates, rounding ties, time wrap
    task automatic test_speed_limits();
        set_config(8'd0, 8'd0);
        send_sample(12'd2047, 32'd71);
        send_sample(12'hFFF, 32'd72);
        send_sample(12'hFFF, 32'd72);
        drain_results();
        set_config(8'd3, 8'd255);
        send_sample(12'hFFF, 32'd75);
        send_sample(12'd0, 32'd1327);
        send_sample(12'd1, 32'd2327);
        drain_results();
        set_config(8'd255, 8'd1);
        send_sample(12'd2, 32'd2400);
        send_sample(12'd2, 32'hFFFF_FFF0);
        send_sample(12'd3, 32'h0000_0100);
        send_sample(12'd2, 32'h0000_04E8);
        drain_results();
        stim_time = trk_last_time;
        stim_angle = trk_angle;
    endtask

    task automatic run_random_phase(int unsigned count, logic [CFG_W-1:0] ival,
                                    logic [CFG_W-1:0] mdt, sink_mode_t mode, bit gaps);
        drain_results();
        set_config(ival, mdt);
        rx_mode = mode;
        tx_gaps = gaps;
        send_random_items(count);
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] ival;
        logic [CFG_W-1:0] mdt;
        run_random_phase(200, 8'd10, 8'd8, RX_RANDOM, 1'b1);
        run_random_phase(200, 8'd0, 8'd1, RX_PATTERN, 1'b1);
        stim_time = 32'hFFFF_8000;
        run_random_phase(200, 8'd255, 8'd255, RX_BURSTY, 1'b1);
        run_random_phase(200, 8'd1, 8'd0, RX_STEADY, 1'b0);
        ival = $urandom;
        mdt = $urandom;
        run_random_phase(200, ival, mdt, RX_RANDOM, 1'b1);
        run_random_phase(200, 8'd5, 8'd20, RX_PATTERN, 1'b1);
        drain_results();
    endtask

    // Hold the result side off long enough for the input to back up
    task automatic test_backpressure();
        set_config(8'd2, 8'd4);
        rx_mode = RX_RANDOM;
        tx_gaps = 1'b0;
        hold_request = 1'b1;
        send_random_items(50);
        drain_results();
    endtask

    // Result sink: stall pattern per mode, plus a long hold-off on request
    initial begin : result_sink
        int unsigned beat_cycle;
        int unsigned hold_left;
        logic        burst_ready;
        beat_cycle = 0;
        hold_left = 0;
        burst_ready = 1'b1;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            beat_cycle++;
            if (hold_request) begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_STEADY: begin
                        m_tready <= 1'b1;
                    end
                    RX_RANDOM: begin
                        m_tready <= ($urandom_range(0, 3) != 0);
                    end
                    RX_PATTERN: begin
                        m_tready <= ((beat_cycle % 7) < 3);
                    end
                    default: begin
                        if (beat_cycle % 24 == 0) burst_ready = $urandom_range(0, 1);
                        m_tready <= burst_ready;
                    end
                endcase
            end
        end
    end

    // Compare each result beat with the oldest expected report
    always @(posedge aclk) begin : result_check
        tracker_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $error("result beat with nothing expected: tdata=%h tuser=%b", m_tdata, m_tuser);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_tuser !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, m_tuser);
                    error_count++;
                end
                if (m_tdata[POS_W-1:0] !== want.position) begin
                    $error("cumulative_position: expected %0d, got %0d",
                           $signed(want.position), $signed(m_tdata[POS_W-1:0]));
                    error_count++;
                end
                if (m_tdata[SPEED_LSB +: SPEED_W] !== want.speed) begin
                    $error("angular_speed: expected %0d, got %0d",
                           want.speed, $signed(m_tdata[SPEED_LSB +: SPEED_W]));
                    error_count++;
                end
                if (m_tdata[ANGLE_LSB +: ANGLE_W] !== want.angle) begin
                    $error("current_angle: expected %0d, got %0d",
                           want.angle, m_tdata[ANGLE_LSB +: ANGLE_W]);
                    error_count++;
                end
            end
        end
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("rotary_encoder_position_speed_tracker_test: errors");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults_and_unwrap();
        test_speed_limits();
        test_random_phases();
        test_backpressure();
        drain_results();
        if (error_count == 0) begin
            $display("rotary_encoder_position_speed_tracker_test: clean");
        end else begin
            $display("rotary_encoder_position_speed_tracker_test: errors");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/rept_pkg.sv
rtl/rept_serdiv.sv
rtl/rept_speed.sv
rtl/rotary_encoder_position_speed_tracker.sv
verif/rotary_encoder_position_speed_tracker_test.sv
